// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Queue depth, field widths, operation and status codes, cell control.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } spq_entry_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
    } spq_ctrl_t;

endpackage

// File: hdl/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if: request channel of the sorted priority queue
// Valid/ready handshake carrying operation, value and priority.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic signed [spq_pkg::VALUE_W-1:0] item_value;
    logic        [spq_pkg::PRIO_W-1:0]  item_priority;

    modport source (output valid, output op, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input op, input item_value, input item_priority,
                    output ready);
endinterface

// File: hdl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if: response channel of the sorted priority queue
// Valid/ready handshake carrying status, removed entry and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic        [spq_pkg::STAT_W-1:0]  status;
    logic signed [spq_pkg::VALUE_W-1:0] removed_value;
    logic        [spq_pkg::PRIO_W-1:0]  removed_priority;
    logic        [spq_pkg::OCC_W-1:0]   occupancy;

    modport source (output valid, output status, output removed_value,
                    output removed_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input removed_priority, input occupancy, output ready);
endinterface

// File: hdl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: shift-register priority queue
// Keeps up to DEPTH entries sorted by ascending priority number, FIFO among
// equal priorities, and serves the smallest number first.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: op (enqueue or dequeue), item_value and
//   item_priority. rsp returns one response per request: status, the removed
//   head entry (zero unless a dequeue succeeded) and the occupancy after it.
//   The response is registered and shows up in the cycle after the request is
//   taken. Throughput is one request per cycle while rsp is not stalled, set by
//   the cell chain, where every slot compares and shifts in the same cycle.
//   req.ready stays high while the response register is empty or is being
//   drained; if the receiver stalls rsp, the pending response holds and
//   req.ready drops until it is taken. An enqueue on a full queue answers
//   full and a dequeue on an empty queue answers empty, both with no change.
//   Reset clears the entry count and the response valid; slot contents are
//   left as they are and never read until written.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic       clk,
    input  logic       rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    logic                            accept;
    logic                            full;
    logic                            empty;
    logic                            is_enq;
    spq_pkg::spq_ctrl_t              ctrl;
    spq_pkg::spq_entry_t             new_entry;
    spq_pkg::spq_entry_t             cell_entry   [spq_pkg::DEPTH];
    logic                            cell_greater [spq_pkg::DEPTH];

    logic [spq_pkg::CNT_W-1:0]       count_reg;
    logic [spq_pkg::CNT_W-1:0]       count_next;

    logic                            rsp_valid_reg;
    logic                            rsp_valid_next;
    spq_pkg::status_t                status_reg;
    spq_pkg::status_t                status_next;
    spq_pkg::spq_entry_t             removed_reg;
    spq_pkg::spq_entry_t             removed_next;
    logic [spq_pkg::OCC_W-1:0]       occ_reg;

    // Take a request whenever the response slot is free or draining.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full   = (count_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign empty  = (count_reg == '0);
    assign is_enq = (req.op == spq_pkg::OP_ENQ);

    assign ctrl.ins = accept && is_enq && !full;
    assign ctrl.del = accept && !is_enq && !empty;

    assign new_entry.value = req.item_value;
    assign new_entry.prio  = req.item_priority;

    // Build the chain: each cell sees its left and right neighbor. The head
    // has no left neighbor and never shifts from it; the tail pulls in a
    // blank entry on removal, which lands beyond the count.
    for (genvar i = 0; i < spq_pkg::DEPTH; i++)
    begin : g_cell
        spq_pkg::spq_entry_t left_e;
        spq_pkg::spq_entry_t right_e;
        logic                left_g;

        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_g = 1'b0;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_g = cell_greater[i-1];
        end

        if (i == spq_pkg::DEPTH - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_mid
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .occupied     (count_reg > spq_pkg::CNT_W'(i)),
            .new_entry    (new_entry),
            .left_entry   (left_e),
            .right_entry  (right_e),
            .left_greater (left_g),
            .greater      (cell_greater[i]),
            .entry        (cell_entry[i])
        );
    end

    // Advance the count and form the response for the request taken now.
    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        removed_next   = removed_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            removed_next   = '0;
            priority if (is_enq && full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else if (is_enq)
            begin
                status_next = spq_pkg::ST_INSERTED;
                count_next  = count_reg + spq_pkg::CNT_W'(1);
            end
            else if (empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                status_next  = spq_pkg::ST_REMOVED;
                removed_next = cell_entry[0];
                count_next   = count_reg - spq_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload: load only with a new request, hold while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            occ_reg     <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.removed_value    = removed_reg.value;
    assign rsp.removed_priority = removed_reg.prio;
    assign rsp.occupancy        = occ_reg;

    // The count never runs past the number of cells.
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
        else $error("entry count exceeds queue depth");

    // The count moves only with a taken request.
    a_count_idle : assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without a request");

    // A refused request leaves the count alone and answers full or empty.
    a_refused : assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((is_enq && full) || (!is_enq && empty)) |=>
            $stable(count_reg) && rsp_valid_reg &&
            (status_reg == spq_pkg::ST_FULL || status_reg == spq_pkg::ST_EMPTY))
        else $error("refused request changed state or answered wrongly");

    // A successful removal hands out exactly the head entry.
    a_head_out : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.del |=> status_reg == spq_pkg::ST_REMOVED &&
            removed_reg == $past(cell_entry[0]))
        else $error("dequeue did not return the head entry");

endmodule

// File: hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the shift-register queue
// Holds one entry; on insert it keeps, takes the new entry or takes the
// left neighbor; on removal it takes the right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  logic               occupied,
    input  spq_pkg::spq_entry_t new_entry,
    input  spq_pkg::spq_entry_t left_entry,
    input  spq_pkg::spq_entry_t right_entry,
    input  logic               left_greater,
    output logic               greater,
    output spq_pkg::spq_entry_t entry
);

    spq_pkg::spq_entry_t entry_reg;
    spq_pkg::spq_entry_t entry_next;

    // An empty slot counts as greater, so the new entry lands at the tail.
    assign greater = !occupied || (entry_reg.prio > new_entry.prio);
    assign entry   = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins && greater)
        begin
            entry_next = left_greater ? left_entry : new_entry;
        end
        else if (ctrl.del)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: test/sorted_priority_queue_checker.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker: response predictor and scoreboard
// Watches both channels. Every accepted request runs through a model of the
// sorted queue and the response it must cause waits in order. Every accepted
// response is compared field by field against the oldest waiting one.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker
(
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    output int   fail_count,
    output int   pending_count
);

    typedef struct packed {
        spq_pkg::status_t                    status;
        logic signed [spq_pkg::VALUE_W-1:0]  value;
        logic        [spq_pkg::PRIO_W-1:0]   prio;
        logic        [spq_pkg::OCC_W-1:0]    occupancy;
    } queue_response_t;

    spq_pkg::spq_entry_t held_entries [spq_pkg::DEPTH];
    int                  held_count;
    queue_response_t     awaited_responses [$];

    initial begin
        held_count    = 0;
        fail_count    = 0;
        pending_count = 0;
    end

    // Apply one request to the held entries and return the response it causes.
    function automatic queue_response_t serve_request(
        spq_pkg::op_t                       op,
        logic signed [spq_pkg::VALUE_W-1:0] value,
        logic        [spq_pkg::PRIO_W-1:0]  prio);
        queue_response_t resp;
        int              pos;
        resp = '{status: spq_pkg::ST_INSERTED, value: '0, prio: '0, occupancy: '0};
        if (op == spq_pkg::OP_ENQ) begin
            if (held_count >= spq_pkg::DEPTH)
                resp.status = spq_pkg::ST_FULL;
            else begin
                // shift every entry with a larger number one slot back
                pos = held_count;
                while (pos > 0 && held_entries[pos-1].prio > prio)
                begin
                    held_entries[pos] = held_entries[pos-1];
                    pos--;
                end
                held_entries[pos] = '{value: value, prio: prio};
                held_count++;
            end
        end
        else if (held_count == 0)
            resp.status = spq_pkg::ST_EMPTY;
        else begin
            resp.status = spq_pkg::ST_REMOVED;
            resp.value  = held_entries[0].value;
            resp.prio   = held_entries[0].prio;
            for (int i = 1; i < held_count; i++)
                held_entries[i-1] = held_entries[i];
            held_count--;
        end
        resp.occupancy = spq_pkg::OCC_W'(held_count);
        return resp;
    endfunction

    task automatic check_field(string name, logic [spq_pkg::VALUE_W-1:0] want,
                               logic [spq_pkg::VALUE_W-1:0] seen);
        if (seen !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
        end
    endtask

    always @(posedge clk)
    begin
        queue_response_t want;
        if (rst_n)
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                awaited_responses.push_back(serve_request(spq_pkg::op_t'(req.op),
                                                          req.item_value,
                                                          req.item_priority));
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (awaited_responses.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected response, status %h value %h prio %h occ %h",
                             $time, rsp.status, rsp.removed_value, rsp.removed_priority,
                             rsp.occupancy);
                end
                else begin
                    want = awaited_responses.pop_front();
                    check_field("status", spq_pkg::VALUE_W'(want.status),
                                spq_pkg::VALUE_W'(rsp.status));
                    check_field("removed_value", want.value, rsp.removed_value);
                    check_field("removed_priority", spq_pkg::VALUE_W'(want.prio),
                                spq_pkg::VALUE_W'(rsp.removed_priority));
                    check_field("occupancy", spq_pkg::VALUE_W'(want.occupancy),
                                spq_pkg::VALUE_W'(rsp.occupancy));
                end
            end
            pending_count = awaited_responses.size();
        end
    end

endmodule

// File: test/sorted_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb: top of the priority queue testbench
// Drives directed then random enqueue/dequeue requests with random idle gaps
// on both channels, a long response stall and a full drain pause. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;

    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_REQUESTS = 1500;
    localparam int STALL_CYCLES    = 80;    // long receiver hold-off
    localparam int SETTLE_CYCLES   = 10;    // margin after the last response
    localparam int CYCLE_LIMIT     = 400000;

    // Priorities and values of the directed fill: extremes and repeated numbers,
    // so that ties must come back in arrival order.
    localparam logic [16*spq_pkg::PRIO_W-1:0] FILL_PRIOS = {
        8'd255, 8'd0,   8'd128, 8'd128, 8'd128, 8'd255, 8'd0,  8'd64,
        8'd1,   8'd254, 8'd128, 8'd0,   8'd64,  8'd255, 8'd1,  8'd127
    };
    localparam logic [16*spq_pkg::VALUE_W-1:0] FILL_VALUES = {
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678,
        32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_0002, 32'h0000_0003,
        32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0004, 32'h0000_0005
    };

    logic        clk = 1'b0;
    logic        rst_n;
    int          fail_count;
    int          pending_count;
    int unsigned cycle_count = 0;

    // Idle controls shared between the request and response processes.
    bit          sender_gaps   = 1'b1;
    bit          receiver_gaps = 1'b1;
    bit          stall_receiver = 1'b0;

    spq_req_if req();
    spq_rsp_if rsp();

    sorted_priority_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    sorted_priority_queue_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hold reset low, then release it at a rising edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one request and hold it until taken, then idle for a random gap if sender gaps are on.
    // Called at a rising edge; returns at a rising edge.
    task automatic send_request(spq_pkg::op_t op,
                                logic signed [spq_pkg::VALUE_W-1:0] value,
                                logic [spq_pkg::PRIO_W-1:0] prio);
        int gap;
        req.op            <= op;
        req.item_value    <= value;
        req.item_priority <= prio;
        req.valid         <= 1'b1;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every outstanding response to come back.
    task automatic wait_for_drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Response side: random ready with gaps, open stretches, and one long
    // hold-off counted here while the sender keeps pushing requests.
    initial
    begin
        int run;
        int gap;
        int stall_count;
        forever
        begin
            if (stall_receiver)
            begin
                rsp.ready <= 1'b0;
                for (stall_count = 0; stall_count < STALL_CYCLES; stall_count++)
                    @(posedge clk);
                stall_receiver = 1'b0;
            end
            else if (!receiver_gaps)
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
            else begin
                run = $urandom_range(1, 8);
                rsp.ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    rsp.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // Request side: directed requests first, then random phases.
    initial
    begin
        int                                 enq_percent;
        int                                 phase_left;
        int                                 roll;
        int                                 segment;
        spq_pkg::op_t                       op;
        logic signed [spq_pkg::VALUE_W-1:0] value;
        logic        [spq_pkg::PRIO_W-1:0]  prio;

        req.valid         <= 1'b0;
        req.op            <= spq_pkg::OP_ENQ;
        req.item_value    <= '0;
        req.item_priority <= '0;
        @(posedge clk iff rst_n);

        // Dequeue from the empty queue: refused.
        send_request(spq_pkg::OP_DEQ, 32'sh7FFF_FFFF, 8'hFF);
        // Fill to capacity with extremes and ties.
        for (int i = 0; i < spq_pkg::DEPTH; i++)
            send_request(spq_pkg::OP_ENQ,
                         FILL_VALUES[(i % 16)*spq_pkg::VALUE_W +: spq_pkg::VALUE_W],
                         FILL_PRIOS[(i % 16)*spq_pkg::PRIO_W +: spq_pkg::PRIO_W]);
        // Enqueue into the full queue: refused even though it would head the line.
        send_request(spq_pkg::OP_ENQ, 32'sh8000_0000, 8'h00);
        // Pull a few heads to see the sort order and tie order.
        repeat (6) send_request(spq_pkg::OP_DEQ, '0, '0);

        enq_percent = 50;
        phase_left  = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // Alternate idle behavior in segments, including one with none.
            segment       = n / 250;
            sender_gaps   = (segment % 4) != 1;
            receiver_gaps = (segment % 4) != 1 && (segment % 4) != 3;

            if (n == 500)
                stall_receiver = 1'b1;
            if (n == 1000)
                wait_for_drain();

            // Swing between filling and emptying phases so the queue hits
            // both the full and the empty refusal often.
            if (phase_left == 0)
            begin
                phase_left  = $urandom_range(20, 60);
                enq_percent = (enq_percent > 50) ? $urandom_range(15, 30)
                                                 : $urandom_range(70, 85);
            end
            phase_left--;
            op = ($urandom_range(0, 99) < enq_percent) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;

            roll = $urandom_range(0, 99);
            if (roll < 40)
                prio = spq_pkg::PRIO_W'($urandom_range(0, 3));
            else if (roll < 50)
                prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                prio = spq_pkg::PRIO_W'($urandom_range(0, 255));

            roll = $urandom_range(0, 99);
            case (roll % 4)
                0: value = (roll < 10) ? 32'sh7FFF_FFFF : $urandom;
                1: value = (roll < 10) ? 32'sh8000_0000 : $urandom;
                2: value = (roll < 10) ? 32'sh0000_0000 : $urandom;
                default: value = (roll < 10) ? -32'sd1 : $urandom;
            endcase

            send_request(op, value, prio);
        end

        // Let every response come back, then allow the pipeline to settle.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
hdl/spq_pkg.sv
hdl/spq_req_if.sv
hdl/spq_rsp_if.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
test/sorted_priority_queue_checker.sv
test/sorted_priority_queue_tb.sv
